[rtl/irfd_pkg.sv]
package irfd_pkg;

    // frame geometry
    localparam int DATA_BITS  = 32;
    localparam int POS_W      = 6;
    localparam int PERIOD_W   = 17;
    localparam int SHIFT_W    = 32;
    localparam logic [POS_W-1:0] POS_LEADER = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(DATA_BITS + 1);

    // register port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_LEADER_MIN = 3'd0,
        REG_LEADER_MAX = 3'd1,
        REG_HEADER_MIN = 3'd2,
        REG_HEADER_MAX = 3'd3,
        REG_ONE_MIN    = 3'd4,
        REG_ONE_MAX    = 3'd5,
        REG_ZERO_MIN   = 3'd6,
        REG_ZERO_MAX   = 3'd7
    } reg_idx_t;

    // register reset values
    localparam logic [PERIOD_W-1:0] LEADER_MIN_RST = PERIOD_W'(70000);
    localparam logic [PERIOD_W-1:0] LEADER_MAX_RST = PERIOD_W'(130000);
    localparam logic [PERIOD_W-1:0] HEADER_MIN_RST = PERIOD_W'(120);
    localparam logic [PERIOD_W-1:0] HEADER_MAX_RST = PERIOD_W'(300);
    localparam logic [PERIOD_W-1:0] ONE_MIN_RST    = PERIOD_W'(150);
    localparam logic [PERIOD_W-1:0] ONE_MAX_RST    = PERIOD_W'(200);
    localparam logic [PERIOD_W-1:0] ZERO_MIN_RST   = PERIOD_W'(200);
    localparam logic [PERIOD_W-1:0] ZERO_MAX_RST   = PERIOD_W'(270);

    // result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_BIT = 1'b1;

    typedef struct packed {
        logic [15:0] capture;
        logic        overflow;
    } cap_t;

    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] address;
        logic        status;
    } frame_t;

    // open window test
    function automatic logic in_window(
        input logic [PERIOD_W-1:0] p,
        input logic [PERIOD_W-1:0] lo,
        input logic [PERIOD_W-1:0] hi
    );
        in_window = (p > lo) && (p < hi);
    endfunction

endpackage

[rtl/ir_pulse_width_frame_decoder.sv]
// IR pulse-width frame decoder
//
// cap channel: one beat per measured edge-to-edge period (16-bit timer
// capture plus an overflow flag worth 65536). The first period of a frame
// must fall in the leader window, the second in the header window, then
// DATA_BITS periods are decoded as ones or zeros by their windows.
// frame channel: one beat per completed frame (command, address, status 0)
// or per data period outside both bit windows (status 1, fields zero).
// Windows are set through the register port, one 17-bit bound per word,
// and must only be changed while the block is idle.
//
// A period is captured in the input register, decoded from there, and its
// result beat is held in the output register. One period is taken every
// cycle while no result is stalled; the decode is a single
// compare-and-shift between the input register and the output register.
// Reset returns the window registers to their defaults and the decoder to
// waiting for a leader. When frame_ready is low the waiting result holds;
// periods that give no result keep flowing, and one more period is taken
// into the input register before cap_ready drops.
module ir_pulse_width_frame_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cap_valid,
    output logic                  cap_ready,
    input  irfd_pkg::cap_t        cap,
    output logic                  frame_valid,
    input  logic                  frame_ready,
    output irfd_pkg::frame_t      frame,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [irfd_pkg::ADDR_W-1:0] paddr,
    input  logic [irfd_pkg::DATA_W-1:0] pwdata,
    output logic [irfd_pkg::DATA_W-1:0] prdata,
    output logic                  pready
);
    import irfd_pkg::*;

    logic [PERIOD_W-1:0] leader_min_reg, leader_max_reg;
    logic [PERIOD_W-1:0] header_min_reg, header_max_reg;
    logic [PERIOD_W-1:0] one_min_reg, one_max_reg;
    logic [PERIOD_W-1:0] zero_min_reg, zero_max_reg;

    logic                s1_valid_reg;
    cap_t                s1_data_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic                out_valid_reg, out_valid_next;
    frame_t              out_data_reg;

    logic [PERIOD_W-1:0] period;
    logic                leader_hit, header_hit, one_hit, zero_hit;
    logic                s1_result, s1_advance, cfg_wr;
    frame_t              res_data;
    reg_idx_t            reg_idx;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        case (reg_idx)
            REG_LEADER_MIN: prdata = DATA_W'(leader_min_reg);
            REG_LEADER_MAX: prdata = DATA_W'(leader_max_reg);
            REG_HEADER_MIN: prdata = DATA_W'(header_min_reg);
            REG_HEADER_MAX: prdata = DATA_W'(header_max_reg);
            REG_ONE_MIN:    prdata = DATA_W'(one_min_reg);
            REG_ONE_MAX:    prdata = DATA_W'(one_max_reg);
            REG_ZERO_MIN:   prdata = DATA_W'(zero_min_reg);
            REG_ZERO_MAX:   prdata = DATA_W'(zero_max_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_min_reg <= LEADER_MIN_RST;
            leader_max_reg <= LEADER_MAX_RST;
            header_min_reg <= HEADER_MIN_RST;
            header_max_reg <= HEADER_MAX_RST;
            one_min_reg    <= ONE_MIN_RST;
            one_max_reg    <= ONE_MAX_RST;
            zero_min_reg   <= ZERO_MIN_RST;
            zero_max_reg   <= ZERO_MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_LEADER_MIN: leader_min_reg <= pwdata[PERIOD_W-1:0];
                REG_LEADER_MAX: leader_max_reg <= pwdata[PERIOD_W-1:0];
                REG_HEADER_MIN: header_min_reg <= pwdata[PERIOD_W-1:0];
                REG_HEADER_MAX: header_max_reg <= pwdata[PERIOD_W-1:0];
                REG_ONE_MIN:    one_min_reg    <= pwdata[PERIOD_W-1:0];
                REG_ONE_MAX:    one_max_reg    <= pwdata[PERIOD_W-1:0];
                REG_ZERO_MIN:   zero_min_reg   <= pwdata[PERIOD_W-1:0];
                REG_ZERO_MAX:   zero_max_reg   <= pwdata[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    // window compares on the registered period
    assign period     = {s1_data_reg.overflow, s1_data_reg.capture};
    assign leader_hit = in_window(period, leader_min_reg, leader_max_reg);
    assign header_hit = in_window(period, header_min_reg, header_max_reg);
    assign one_hit    = in_window(period, one_min_reg, one_max_reg);
    assign zero_hit   = in_window(period, zero_min_reg, zero_max_reg);

    // frame position step and bit shift
    always_comb
    begin
        pos_next          = pos_reg;
        shift_next        = shift_reg;
        s1_result         = 1'b0;
        res_data.command  = '0;
        res_data.address  = '0;
        res_data.status   = STATUS_OK;
        if (pos_reg == POS_LEADER || pos_reg > POS_LAST)
        begin
            pos_next = POS_LEADER;
            if (leader_hit)
            begin
                pos_next   = POS_HEADER;
                shift_next = '0;
            end
        end
        else if (pos_reg == POS_HEADER)
        begin
            pos_next = header_hit ? POS_W'(2) : POS_LEADER;
        end
        else if (one_hit || zero_hit)
        begin
            shift_next = {one_hit, shift_reg[SHIFT_W-1:1]};
            if (pos_reg == POS_LAST)
            begin
                pos_next         = POS_LEADER;
                s1_result        = 1'b1;
                res_data.command = shift_next[31:24];
                res_data.address = shift_next[15:0];
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else
        begin
            pos_next        = POS_LEADER;
            s1_result       = 1'b1;
            res_data.status = STATUS_BAD_BIT;
        end
    end

    // handshakes
    assign s1_advance  = s1_valid_reg && (!s1_result || !out_valid_reg || frame_ready);
    assign cap_ready   = !s1_valid_reg || s1_advance;
    assign frame_valid = out_valid_reg;
    assign frame       = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_result)
            out_valid_next = 1'b1;
        else if (frame_ready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_LEADER;
            shift_reg     <= '0;
        end
        else
        begin
            if (cap_ready)
                s1_valid_reg <= cap_valid;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                pos_reg   <= pos_next;
                shift_reg <= shift_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cap_valid && cap_ready)
            s1_data_reg <= cap;
        if (s1_advance && s1_result)
            out_data_reg <= res_data;
    end

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("frame position beyond last data bit");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == STATUS_BAD_BIT)
        |-> (out_data_reg.command == 8'd0 && out_data_reg.address == 16'd0))
        else $error("error beat carries non-zero fields");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_result) |=> out_valid_reg)
        else $error("decoded result not held in output register");

    a_leader_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && pos_reg == POS_LEADER && leader_hit)
        |=> (pos_reg == POS_HEADER && shift_reg == '0))
        else $error("leader did not start a fresh frame");

    a_result_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_result) |=> pos_reg == POS_LEADER)
        else $error("frame position not reset after result");

endmodule
